// File: hdl/pie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pie_pkg
// Types, constants and helpers shared by the price indicator engine.
// ----------------------------------------------------------------------------
package pie_pkg;

  localparam int PRICE_W  = 32;
  localparam int KW       = 7;    // walk index, 0..63
  localparam int SUM_W    = 38;   // sum of up to 64 prices
  localparam int GL_W     = 37;   // sum of up to 32 price differences
  localparam int RSI_W    = 23;
  localparam int TRD_W    = 18;
  localparam int ZONE_W   = 31;
  localparam int OUT_W    = 176;  // 170 bits of fields, padded to bytes

  localparam int MAX_MA   = 64;
  localparam int MAX_RSI  = 32;

  localparam logic [1:0]  CFG_MA    = 2'd0;
  localparam logic [1:0]  CFG_ALPHA = 2'd1;
  localparam logic [1:0]  CFG_RSI   = 2'd2;

  localparam logic [6:0]  MA_RESET    = 7'd20;
  localparam logic [16:0] ALPHA_RESET = 17'd6242;
  localparam logic [5:0]  RSI_RESET   = 6'd14;
  localparam logic [16:0] ALPHA_ONE   = 17'd65536;

  localparam logic [RSI_W-1:0] RSI_FULL = 23'd6553600;
  localparam logic [31:0] DIV_LOOKBACK  = 32'd10;
  localparam logic [31:0] DIV_MIN_CNT   = 32'd30;
  localparam logic [31:0] TREND_MIN_CNT = 32'd10;

  localparam logic [1:0]  DIV_NONE = 2'd0;
  localparam logic [1:0]  DIV_BULL = 2'd1;
  localparam logic [1:0]  DIV_BEAR = 2'd2;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_WALK = 7'b0000100,
    ST_DSET = 7'b0001000,
    ST_DRUN = 7'b0010000,
    ST_DSTO = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    JOB_SMA  = 3'd0,
    JOB_RSI  = 3'd1,
    JOB_OLD  = 3'd2,
    JOB_TRD  = 3'd3,
    JOB_ZONE = 3'd4
  } job_t;

  // gain * 100 * 2^16 by shift and add (100 = 64 + 32 + 4)
  function automatic logic [63:0] rsi_scale(input logic [GL_W-1:0] g);
    logic [63:0] ge;
    ge = 64'(g);
    return (ge << 22) + (ge << 21) + (ge << 18);
  endfunction

endpackage

// File: hdl/pie_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/price_indicator_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_indicator_engine
// Per-price SMA, windowed EMA, RSI, RSI divergence, trend strength and
// magnetic zone over a ring of recent prices and whole-series counters.
// ----------------------------------------------------------------------------
// Work per price: a history walk (one RAM read a cycle), then five radix-2
//   divisions (32+23+23+17+32 quotient bits) on one shared divider.
// Flow: in_tready is high only when idle; a new price is taken only once the
//   last result has been loaded into the output register.
// Reset: synchronous active-low rst_n clears counters, pointer and control;
//   history RAM is not cleared; stale entries may be read but are count-gated.
module price_indicator_engine
  import pie_pkg::*;
#(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [16:0]       cfg_wdata,
  // price input
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [31:0] close_price
  input  logic [0:0]        in_tuser,   // [0] restart
  // indicator output
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // [31:0] sample_count, [63:32] sma_value,
                                        // [95:64] ema_value, [118:96] rsi_value,
                                        // [120:119] rsi_divergence,
                                        // [138:121] trend_strength,
                                        // [169:139] magnetic_zone, rest zero
);

  localparam int AW       = $clog2(HISTORY_DEPTH);
  localparam int IW       = ((AW > KW) ? AW : KW) + 1;
  localparam int MA_LIMIT = (HISTORY_DEPTH < MAX_MA) ? HISTORY_DEPTH : MAX_MA;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t            state_r;
  job_t              job_r;

  logic [6:0]        ma_cfg_r;
  logic [16:0]       alpha_cfg_r;
  logic [5:0]        rsi_cfg_r;

  // series state
  logic [AW-1:0]     wp_r, last_idx_r;
  logic [31:0]       cnt_r, up_r, down_r, last_price_r;
  logic [63:0]       total_r;

  // per-transaction snapshot
  logic [31:0]       price_r, n_r;
  logic [6:0]        ma_r;
  logic [5:0]        rp_r;
  logic [16:0]       alpha_r;
  logic [63:0]       prod_r;

  // history walk
  logic [KW-1:0]     k0_r, walk_k_r, rd_k_r;
  logic              issue_r, rd_vld_r;
  logic [SUM_W-1:0]  sum_r;
  logic [GL_W-1:0]   gn_r, ls_r, go_r, lo_r;
  logic [31:0]       ema_r, prev_r, p10_r;

  // shared divider
  logic [63:0]       div_num_r;
  logic [SUM_W-1:0]  div_den_r, div_rem_r;
  logic [31:0]       div_quo_r;
  logic [5:0]        div_cnt_r;

  // division results
  logic [31:0]       sma_q_r, zone_q_r;
  logic [SUM_W-1:0]  zone_rem_r;
  logic [RSI_W-1:0]  rsi_q_r, old_q_r;
  logic [16:0]       trd_q_r;

  logic              out_tvalid_r;
  logic [OUT_W-1:0]  out_tdata_r;

  // --------------------------------------------------------------------------
  // Accept and series counter update
  // --------------------------------------------------------------------------
  logic              accept;
  logic              restart;
  logic [31:0]       price_in;
  logic [31:0]       cnt_base, up_base, down_base;
  logic [63:0]       total_base;
  logic [AW-1:0]     wp_base;
  logic [31:0]       cnt_nxt, up_nxt, down_nxt;
  logic [63:0]       total_nxt;
  logic [AW-1:0]     wp_nxt;
  logic [6:0]        ma_clamp;
  logic [5:0]        rp_clamp;
  logic [16:0]       alpha_clamp;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign restart   = in_tuser[0];
  assign price_in  = in_tdata;

  always_comb begin
    cnt_base   = restart ? '0 : cnt_r;
    up_base    = restart ? '0 : up_r;
    down_base  = restart ? '0 : down_r;
    total_base = restart ? '0 : total_r;
    wp_base    = restart ? '0 : wp_r;

    up_nxt    = up_base;
    down_nxt  = down_base;
    if (cnt_base != '0) begin
      if (price_in > last_price_r) begin
        if (up_base != '1) up_nxt = up_base + 32'd1;
      end else if (price_in < last_price_r) begin
        if (down_base != '1) down_nxt = down_base + 32'd1;
      end
    end

    cnt_nxt   = cnt_base;
    total_nxt = total_base;
    if (cnt_base != '1) begin
      cnt_nxt   = cnt_base + 32'd1;
      total_nxt = total_base + 64'(price_in);
    end

    wp_nxt = (wp_base == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_base + AW'(1);

    // out-of-range settings act as the nearest legal value
    if (ma_cfg_r == '0)                  ma_clamp = 7'd1;
    else if (ma_cfg_r > 7'(MA_LIMIT))    ma_clamp = 7'(MA_LIMIT);
    else                                 ma_clamp = ma_cfg_r;
    if (rsi_cfg_r == '0)                 rp_clamp = 6'd1;
    else if (rsi_cfg_r > 6'(MAX_RSI))    rp_clamp = 6'(MAX_RSI);
    else                                 rp_clamp = rsi_cfg_r;
    alpha_clamp = (alpha_cfg_r > ALPHA_ONE) ? ALPHA_ONE : alpha_cfg_r;
  end

  // --------------------------------------------------------------------------
  // History RAM: written on accept, read back(k) during the walk
  // --------------------------------------------------------------------------
  logic [AW-1:0]     ram_raddr;
  logic [31:0]       ram_rdata;
  logic [IW-1:0]     k_ext, last_ext;

  always_comb begin
    k_ext    = IW'(walk_k_r);
    last_ext = IW'(last_idx_r);
    if (k_ext > last_ext) ram_raddr = AW'(last_ext + IW'(HISTORY_DEPTH) - k_ext);
    else                  ram_raddr = AW'(last_ext - k_ext);
  end

  pie_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (accept),
    .waddr (wp_base),
    .wdata (price_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Walk datapath: one history entry per cycle, k from oldest needed to 0
  // --------------------------------------------------------------------------
  logic               x_gt;
  logic [31:0]        d_up, d_dn;
  logic signed [32:0] ema_d;
  logic signed [50:0] ema_p;
  logic signed [51:0] ema_s;
  logic [31:0]        ema_step;
  logic               pair_ok, now_pair, old_pair;
  logic [6:0]         rp_ext;

  always_comb begin
    x_gt  = ram_rdata > prev_r;
    d_up  = ram_rdata - prev_r;
    d_dn  = prev_r - ram_rdata;
    // e + alpha*(x - e), same value as alpha*x + (1-alpha)*e
    ema_d = $signed({1'b0, ram_rdata}) - $signed({1'b0, ema_r});
    ema_p = ema_d * $signed({1'b0, alpha_r});
    ema_s = $signed({4'b0, ema_r, 16'b0}) + $signed({ema_p[50], ema_p})
            + 52'sd32768;
    ema_step = ema_s[47:16];
    rp_ext   = 7'(rp_r);
    pair_ok  = rd_k_r < k0_r;
    now_pair = pair_ok && (rd_k_r < rp_ext);
    old_pair = pair_ok && (rd_k_r >= 7'(DIV_LOOKBACK))
               && (rd_k_r < rp_ext + 7'(DIV_LOOKBACK));
  end

  // --------------------------------------------------------------------------
  // Divider setup per job
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]  rsi_s, old_s, zone_den;
  logic [32:0]       mv_tot;
  logic              trd_neg, zone_neg;
  logic [31:0]       trd_mag;
  logic [63:0]       zone_mag;
  logic [63:0]       set_num;
  logic [SUM_W-1:0]  set_den;
  logic [5:0]        set_q;

  always_comb begin
    rsi_s    = SUM_W'(gn_r) + SUM_W'(ls_r);
    old_s    = SUM_W'(go_r) + SUM_W'(lo_r);
    mv_tot   = 33'(up_r) + 33'(down_r);
    trd_neg  = down_r > up_r;
    trd_mag  = trd_neg ? down_r - up_r : up_r - down_r;
    zone_neg = prod_r < total_r;
    zone_mag = zone_neg ? total_r - prod_r : prod_r - total_r;
    zone_den = SUM_W'({n_r, 2'b00}) + SUM_W'(n_r);

    unique case (job_r)
      JOB_SMA: begin
        set_num = 64'(sum_r);
        set_den = SUM_W'(ma_r);
        set_q   = 6'd32;
      end
      JOB_RSI: begin
        set_num = rsi_scale(gn_r) + 64'(rsi_s >> 1);
        set_den = (rsi_s == '0) ? SUM_W'(1) : rsi_s;
        set_q   = 6'd23;
      end
      JOB_OLD: begin
        set_num = rsi_scale(go_r) + 64'(old_s >> 1);
        set_den = (old_s == '0) ? SUM_W'(1) : old_s;
        set_q   = 6'd23;
      end
      JOB_TRD: begin
        set_num = {16'b0, trd_mag, 16'b0} + 64'(mv_tot >> 1);
        set_den = (mv_tot == '0) ? SUM_W'(1) : SUM_W'(mv_tot);
        set_q   = 6'd17;
      end
      JOB_ZONE: begin
        set_num = zone_mag;
        set_den = zone_den;
        set_q   = 6'd32;
      end
      default: begin
        set_num = '0;
        set_den = SUM_W'(1);
        set_q   = 6'd32;
      end
    endcase
  end

  // restoring step: one quotient bit per cycle
  logic [SUM_W:0]    div_t;
  logic              div_ge;
  logic [SUM_W-1:0]  div_rem_step;

  always_comb begin
    div_t        = {div_rem_r, div_num_r[63]};
    div_ge       = div_t >= {1'b0, div_den_r};
    div_rem_step = div_ge ? SUM_W'(div_t - {1'b0, div_den_r}) : div_t[SUM_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Result assembly
  // --------------------------------------------------------------------------
  logic [RSI_W-1:0]  rsi_v, old_v;
  logic [1:0]        div_code;
  logic [TRD_W-1:0]  trend_v;
  logic              zone_up;
  logic [32:0]       zone_qr;
  logic [ZONE_W-1:0] zone_v;
  logic [31:0]       sma_v, ema_v;
  logic              sma_ok, div_ok;

  always_comb begin
    sma_ok = n_r >= 32'(ma_r);
    sma_v  = sma_ok ? sma_q_r : '0;
    ema_v  = sma_ok ? ema_r : '0;

    if (n_r <= 32'(rp_r))  rsi_v = '0;
    else if (ls_r == '0)   rsi_v = RSI_FULL;
    else                   rsi_v = rsi_q_r;

    if ((n_r - DIV_LOOKBACK) <= 32'(rp_r)) old_v = '0;
    else if (lo_r == '0)                   old_v = RSI_FULL;
    else                                   old_v = old_q_r;

    div_ok   = n_r >= DIV_MIN_CNT;
    div_code = DIV_NONE;
    if (div_ok) begin
      if (price_r > p10_r && rsi_v < old_v)      div_code = DIV_BEAR;
      else if (price_r < p10_r && rsi_v > old_v) div_code = DIV_BULL;
    end

    trend_v = '0;
    if (n_r >= TREND_MIN_CNT && mv_tot != '0) begin
      trend_v = trd_neg ? TRD_W'(-{1'b0, trd_q_r}) : TRD_W'({1'b0, trd_q_r});
    end

    // halves round away from zero
    zone_up = {zone_rem_r, 1'b0} >= {1'b0, zone_den};
    zone_qr = 33'(zone_q_r) + 33'(zone_up);
    zone_v  = zone_neg ? ZONE_W'(-zone_qr) : zone_qr[ZONE_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic out_load;
  assign out_load = (state_r == ST_FIN) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      job_r        <= JOB_SMA;
      ma_cfg_r     <= MA_RESET;
      alpha_cfg_r  <= ALPHA_RESET;
      rsi_cfg_r    <= RSI_RESET;
      wp_r         <= '0;
      cnt_r        <= '0;
      up_r         <= '0;
      down_r       <= '0;
      total_r      <= '0;
      issue_r      <= 1'b0;
      rd_vld_r     <= 1'b0;
      walk_k_r     <= '0;
      div_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_MA:    ma_cfg_r    <= cfg_wdata[6:0];
          CFG_ALPHA: alpha_cfg_r <= cfg_wdata;
          CFG_RSI:   rsi_cfg_r   <= cfg_wdata[5:0];
          default: ;
        endcase
      end

      // a new result load keeps valid high in the same cycle
      if (out_tvalid_r && out_tready && !out_load) out_tvalid_r <= 1'b0;
      rd_vld_r <= (state_r == ST_WALK) && issue_r;

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            wp_r    <= wp_nxt;
            cnt_r   <= cnt_nxt;
            up_r    <= up_nxt;
            down_r  <= down_nxt;
            total_r <= total_nxt;
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          walk_k_r <= (ma_r - 7'd1 > rp_ext + 7'(DIV_LOOKBACK)) ?
                      ma_r - 7'd1 : rp_ext + 7'(DIV_LOOKBACK);
          issue_r  <= 1'b1;
          state_r  <= ST_WALK;
        end
        ST_WALK: begin
          if (issue_r) begin
            if (walk_k_r == '0) issue_r  <= 1'b0;
            else                walk_k_r <= walk_k_r - 7'd1;
          end
          if (rd_vld_r && rd_k_r == '0) begin
            job_r   <= JOB_SMA;
            state_r <= ST_DSET;
          end
        end
        ST_DSET: begin
          div_cnt_r <= set_q;
          state_r   <= ST_DRUN;
        end
        ST_DRUN: begin
          div_cnt_r <= div_cnt_r - 6'd1;
          if (div_cnt_r == 6'd1) state_r <= ST_DSTO;
        end
        ST_DSTO: begin
          unique case (job_r)
            JOB_SMA:  job_r <= JOB_RSI;
            JOB_RSI:  job_r <= JOB_OLD;
            JOB_OLD:  job_r <= JOB_TRD;
            JOB_TRD:  job_r <= JOB_ZONE;
            default:  job_r <= JOB_SMA;
          endcase
          state_r <= (job_r == JOB_ZONE) ? ST_FIN : ST_DSET;
        end
        ST_FIN: begin
          if (out_load) begin
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      price_r      <= price_in;
      last_price_r <= price_in;
      last_idx_r   <= wp_base;
      n_r          <= cnt_nxt;
      ma_r         <= ma_clamp;
      rp_r         <= rp_clamp;
      alpha_r      <= alpha_clamp;
    end

    if (state_r == ST_PREP) begin
      prod_r <= 64'(price_r) * 64'(n_r);
      k0_r   <= (ma_r - 7'd1 > rp_ext + 7'(DIV_LOOKBACK)) ?
                ma_r - 7'd1 : rp_ext + 7'(DIV_LOOKBACK);
      sum_r  <= '0;
      gn_r   <= '0;
      ls_r   <= '0;
      go_r   <= '0;
      lo_r   <= '0;
    end

    rd_k_r <= walk_k_r;

    if (state_r == ST_WALK && rd_vld_r) begin
      prev_r <= ram_rdata;
      if (rd_k_r == 7'(DIV_LOOKBACK)) p10_r <= ram_rdata;
      if (rd_k_r < ma_r) sum_r <= sum_r + SUM_W'(ram_rdata);
      if (rd_k_r == ma_r - 7'd1)    ema_r <= ram_rdata;
      else if (rd_k_r < ma_r - 7'd1) ema_r <= ema_step;
      if (now_pair) begin
        if (x_gt) gn_r <= gn_r + GL_W'(d_up);
        else      ls_r <= ls_r + GL_W'(d_dn);
      end
      if (old_pair) begin
        if (x_gt) go_r <= go_r + GL_W'(d_up);
        else      lo_r <= lo_r + GL_W'(d_dn);
      end
    end

    if (state_r == ST_DSET) begin
      div_den_r <= set_den;
      div_rem_r <= SUM_W'(set_num >> set_q);
      div_num_r <= set_num << (7'd64 - 7'(set_q));
      div_quo_r <= '0;
    end

    if (state_r == ST_DRUN) begin
      div_rem_r <= div_rem_step;
      div_num_r <= {div_num_r[62:0], 1'b0};
      div_quo_r <= {div_quo_r[30:0], div_ge};
    end

    if (state_r == ST_DSTO) begin
      unique case (job_r)
        JOB_SMA:  sma_q_r <= div_quo_r;
        JOB_RSI:  rsi_q_r <= div_quo_r[RSI_W-1:0];
        JOB_OLD:  old_q_r <= div_quo_r[RSI_W-1:0];
        JOB_TRD:  trd_q_r <= div_quo_r[16:0];
        JOB_ZONE: begin
          zone_q_r   <= div_quo_r;
          zone_rem_r <= div_rem_r;
        end
        default: ;
      endcase
    end

    if (out_load) begin
      out_tdata_r <= {6'b0, zone_v, trend_v, div_code, rsi_v, ema_v, sma_v, n_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("engine still ready after taking a price");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !restart) |=> cnt_r >= $past(cnt_r))
    else $error("sample count went down without restart");

  a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && rd_vld_r) |-> rd_k_r <= k0_r)
    else $error("walk read beyond start index");

  a_raddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (IW'(ram_raddr) < IW'(HISTORY_DEPTH)))
    else $error("history read address out of range");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_tvalid && in_tready))
    else $error("result not posted on leaving final state");

endmodule
